// ===== rtl/wfba_pkg.sv =====
package wfba_pkg;

   // fixed field widths
   localparam int ADDR_W  = 32;
   localparam int OWNER_W = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int DEF_TABLE_SLOTS = 16;

   // register reset values
   localparam logic [ADDR_W-1:0] TOTAL_RESET    = 32'd65536;
   localparam logic [ADDR_W-1:0] RESERVED_RESET = 32'd1024;

   // register indexes
   localparam logic CSR_TOTAL    = 1'b0;
   localparam logic CSR_RESERVED = 1'b1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOOWNER = 2'd3;

   // owner of the reserved block
   localparam logic [OWNER_W-1:0] OWNER_SYSTEM = 16'd1;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_ALLOC_SCAN, S_ALLOC_COMMIT,
      S_FREE_SCAN, S_MERGE_LEFT, S_MERGE_RIGHT, S_RESPOND
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_SCAN_ALLOC, OP_SCAN_NEXT, OP_FREE_HIT,
      OP_MERGE_LEFT, OP_MERGE_RIGHT, OP_FREE_DONE, OP_ALLOC_COMMIT, OP_INIT
   } dp_op_type;

   typedef enum logic [1:0] {
      RD_CUR, RD_PREV, RD_NEXT
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type         op;
      rd_sel_type        rd_sel;
      logic              set_res;
      logic [STAT_W-1:0] res_status;
      logic              res_grant;
      logic              rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] lat_cmd;
      logic             idx_lt_cnt;
      logic             idx_nz;
      logic             next_lt_cnt;
      logic             rd_free;
      logic             rd_hit;
      logic             found;
      logic             big_gt_req;
      logic             full;
   } dp_stat_type;

endpackage

// ===== rtl/wfba_ctrl.sv =====
module wfba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  wfba_pkg::dp_stat_type stat,
   output wfba_pkg::dp_cmd_type  cmd
);
   import wfba_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      cmd            = '0;
      cmd.op         = OP_NONE;
      cmd.rd_sel     = RD_CUR;
      cmd.res_status = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.lat_cmd)
               CMD_ALLOC: state_in = S_ALLOC_SCAN;
               CMD_FREE:  state_in = S_FREE_SCAN;
               CMD_INIT: begin
                  cmd.op      = OP_INIT;
                  cmd.set_res = 1'b1;
                  state_in    = S_RESPOND;
               end
               default: begin
                  cmd.set_res = 1'b1;
                  state_in    = S_RESPOND;
               end
            endcase
         end
         S_ALLOC_SCAN: begin
            if (stat.idx_lt_cnt) begin
               cmd.op = OP_SCAN_ALLOC;
            end else begin
               state_in = S_ALLOC_COMMIT;
            end
         end
         S_ALLOC_COMMIT: begin
            cmd.set_res = 1'b1;
            state_in    = S_RESPOND;
            if (!stat.found) begin
               cmd.res_status = STAT_NOFIT;
            end else if (stat.big_gt_req && stat.full) begin
               cmd.res_status = STAT_FULL;
            end else begin
               cmd.op        = OP_ALLOC_COMMIT;
               cmd.res_grant = 1'b1;
            end
         end
         S_FREE_SCAN: begin
            if (!stat.idx_lt_cnt) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = STAT_NOOWNER;
               state_in       = S_RESPOND;
            end else if (stat.rd_hit) begin
               cmd.op   = OP_FREE_HIT;
               state_in = S_MERGE_LEFT;
            end else begin
               cmd.op = OP_SCAN_NEXT;
            end
         end
         S_MERGE_LEFT: begin
            cmd.rd_sel = RD_PREV;
            if (stat.idx_nz && stat.rd_free) begin
               cmd.op = OP_MERGE_LEFT;
            end else begin
               state_in = S_MERGE_RIGHT;
            end
         end
         S_MERGE_RIGHT: begin
            cmd.rd_sel = RD_NEXT;
            if (stat.next_lt_cnt && stat.rd_free) begin
               cmd.op = OP_MERGE_RIGHT;
            end else begin
               cmd.op      = OP_FREE_DONE;
               cmd.set_res = 1'b1;
               state_in    = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/wfba_datapath.sv =====
module wfba_datapath #(
   parameter int TABLE_SLOTS = wfba_pkg::DEF_TABLE_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [wfba_pkg::ADDR_W-1:0]   csr_wdata,
   input  logic [wfba_pkg::CMD_W-1:0]    in_command,
   input  logic [wfba_pkg::ADDR_W-1:0]   in_request_size,
   input  logic [wfba_pkg::OWNER_W-1:0]  in_owner_id,
   input  wfba_pkg::dp_cmd_type          cmd,
   output wfba_pkg::dp_stat_type         stat,
   output logic [wfba_pkg::STAT_W-1:0]   out_status,
   output logic [wfba_pkg::ADDR_W-1:0]   out_granted_start,
   output logic [wfba_pkg::ADDR_W-1:0]   out_granted_size
);
   import wfba_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

   // block table
   logic [ADDR_W-1:0]  bstart_ff [TABLE_SLOTS];
   logic [ADDR_W-1:0]  bsize_ff  [TABLE_SLOTS];
   logic               bfree_ff  [TABLE_SLOTS];
   logic [OWNER_W-1:0] bowner_ff [TABLE_SLOTS];

   logic [CW-1:0]      cnt_ff;
   logic [ADDR_W-1:0]  total_ff, reserved_ff;
   logic [CMD_W-1:0]   lcmd_ff;
   logic [ADDR_W-1:0]  lreq_ff;
   logic [OWNER_W-1:0] lowner_ff;
   logic [CW-1:0]      idx_ff;
   logic [IW-1:0]      best_ff;
   logic [ADDR_W-1:0]  big_ff, bigstart_ff, acc_ff;
   logic               found_ff;
   logic [STAT_W-1:0]  res_status_ff, rsp_status_ff;
   logic [ADDR_W-1:0]  res_start_ff, res_size_ff, rsp_start_ff, rsp_size_ff;

   logic [IW-1:0]      cur_idx, rd_idx;
   logic [ADDR_W-1:0]  rd_start, rd_size;
   logic               rd_free;
   logic [OWNER_W-1:0] rd_owner;
   logic [CW-1:0]      next_c;
   logic [IW-1:0]      best_p1;

   assign cur_idx = idx_ff[IW-1:0];
   assign next_c  = idx_ff + CW'(1);
   assign best_p1 = best_ff + IW'(1);

   // single table read port
   always_comb begin
      case (cmd.rd_sel)
         RD_PREV: rd_idx = cur_idx - IW'(1);
         RD_NEXT: rd_idx = cur_idx + IW'(1);
         default: rd_idx = cur_idx;
      endcase
   end
   assign rd_start = bstart_ff[rd_idx];
   assign rd_size  = bsize_ff[rd_idx];
   assign rd_free  = bfree_ff[rd_idx];
   assign rd_owner = bowner_ff[rd_idx];

   // status toward the controller
   always_comb begin
      stat.lat_cmd     = lcmd_ff;
      stat.idx_lt_cnt  = idx_ff < cnt_ff;
      stat.idx_nz      = idx_ff != '0;
      stat.next_lt_cnt = next_c < cnt_ff;
      stat.rd_free     = rd_free;
      stat.rd_hit      = !rd_free && (rd_owner == lowner_ff);
      stat.found       = found_ff;
      stat.big_gt_req  = big_ff > lreq_ff;
      stat.full        = cnt_ff >= SLOTS_C;
   end

   // configuration registers and entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= TOTAL_RESET;
         reserved_ff <= RESERVED_RESET;
         cnt_ff      <= '0;
      end else begin
         if (csr_we && csr_addr == CSR_TOTAL) total_ff <= csr_wdata;
         if (csr_we && csr_addr == CSR_RESERVED) reserved_ff <= csr_wdata;
         case (cmd.op)
            OP_INIT:         cnt_ff <= (reserved_ff < total_ff) ? CW'(2) : CW'(1);
            OP_ALLOC_COMMIT: if (big_ff > lreq_ff) cnt_ff <= cnt_ff + CW'(1);
            OP_MERGE_LEFT,
            OP_MERGE_RIGHT:  cnt_ff <= cnt_ff - CW'(1);
            default: ;
         endcase
      end
   end

   // scan and merge working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            lcmd_ff   <= in_command;
            lreq_ff   <= in_request_size;
            lowner_ff <= in_owner_id;
            idx_ff    <= '0;
            found_ff  <= 1'b0;
            big_ff    <= '0;
         end
         OP_SCAN_ALLOC: begin
            if (rd_free && rd_size >= lreq_ff && rd_size > big_ff) begin
               best_ff     <= cur_idx;
               big_ff      <= rd_size;
               bigstart_ff <= rd_start;
               found_ff    <= 1'b1;
            end
            idx_ff <= next_c;
         end
         OP_SCAN_NEXT:   idx_ff <= next_c;
         OP_FREE_HIT:    acc_ff <= rd_size;
         OP_MERGE_LEFT: begin
            acc_ff <= acc_ff + rd_size;
            idx_ff <= idx_ff - CW'(1);
         end
         OP_MERGE_RIGHT: acc_ff <= acc_ff + rd_size;
         default: ;
      endcase
   end

   // table update, one register per entry
   always_ff @(posedge clock) begin
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         case (cmd.op)
            OP_INIT: begin
               if (k == 0) begin
                  bstart_ff[k] <= '0;
                  bsize_ff[k]  <= reserved_ff;
                  bfree_ff[k]  <= 1'b0;
                  bowner_ff[k] <= OWNER_SYSTEM;
               end else if (k == 1) begin
                  bstart_ff[k] <= reserved_ff;
                  bsize_ff[k]  <= total_ff - reserved_ff;
                  bfree_ff[k]  <= 1'b1;
                  bowner_ff[k] <= '0;
               end
            end
            OP_ALLOC_COMMIT: begin
               if (IW'(k) == best_ff) begin
                  bsize_ff[k]  <= lreq_ff;
                  bfree_ff[k]  <= 1'b0;
                  bowner_ff[k] <= lowner_ff;
               end else if (big_ff > lreq_ff && k > 0) begin
                  if (IW'(k) == best_p1) begin
                     bstart_ff[k] <= bigstart_ff + lreq_ff;
                     bsize_ff[k]  <= big_ff - lreq_ff;
                     bfree_ff[k]  <= 1'b1;
                     bowner_ff[k] <= '0;
                  end else if (IW'(k) > best_p1) begin
                     bstart_ff[k] <= bstart_ff[(k > 0) ? k - 1 : 0];
                     bsize_ff[k]  <= bsize_ff[(k > 0) ? k - 1 : 0];
                     bfree_ff[k]  <= bfree_ff[(k > 0) ? k - 1 : 0];
                     bowner_ff[k] <= bowner_ff[(k > 0) ? k - 1 : 0];
                  end
               end
            end
            OP_MERGE_LEFT, OP_MERGE_RIGHT: begin
               // drop the entry at the current slot or the one after it
               if (k < TABLE_SLOTS - 1 &&
                   ((cmd.op == OP_MERGE_LEFT  && IW'(k) >= cur_idx) ||
                    (cmd.op == OP_MERGE_RIGHT && IW'(k) >  cur_idx))) begin
                  bstart_ff[k] <= bstart_ff[(k < TABLE_SLOTS - 1) ? k + 1 : k];
                  bsize_ff[k]  <= bsize_ff[(k < TABLE_SLOTS - 1) ? k + 1 : k];
                  bfree_ff[k]  <= bfree_ff[(k < TABLE_SLOTS - 1) ? k + 1 : k];
                  bowner_ff[k] <= bowner_ff[(k < TABLE_SLOTS - 1) ? k + 1 : k];
               end
            end
            OP_FREE_DONE: begin
               if (IW'(k) == cur_idx) begin
                  bsize_ff[k]  <= acc_ff;
                  bfree_ff[k]  <= 1'b1;
                  bowner_ff[k] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // result and output registers
   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_start_ff  <= cmd.res_grant ? bigstart_ff : '0;
         res_size_ff   <= cmd.res_grant ? lreq_ff : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign out_status        = rsp_status_ff;
   assign out_granted_start = rsp_start_ff;
   assign out_granted_size  = rsp_size_ff;

endmodule

// ===== rtl/worst_fit_block_allocator_unit.sv =====
// flow: init or an unknown command goes straight to the result; an allocate scans every entry,
//   then commits; a free scans for the owner's block (a no-owner result if there is none),
//   then merges it with its free neighbors
// throughput: one item at a time; the next item can be taken in the same cycle that the result
//   is raised
// reset: synchronous; empties the table and sets total 65536, reserved 1024
module worst_fit_block_allocator_unit #(
   parameter int TABLE_SLOTS = wfba_pkg::DEF_TABLE_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // command[1:0], request_size[33:2], owner_id[49:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status[1:0], granted_start[33:2], granted_size[65:34]
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);
   import wfba_pkg::*;

   dp_cmd_type         cmd;
   dp_stat_type        stat;
   logic [STAT_W-1:0]  o_status;
   logic [ADDR_W-1:0]  o_start, o_size;

   wfba_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   wfba_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .in_command(req_tdata[1:0]),
      .in_request_size(req_tdata[33:2]),
      .in_owner_id(req_tdata[49:34]),
      .cmd(cmd), .stat(stat),
      .out_status(o_status),
      .out_granted_start(o_start),
      .out_granted_size(o_size)
   );

   // result packing
   assign rsp_tdata = {6'd0, o_size, o_start, o_status};

endmodule

// ===== rtl/wfba_checker.sv =====
module wfba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import wfba_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // failed requests grant nothing
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STAT_OK |-> rsp_tdata[65:2] == '0)
      else $error("grant on failed item");

   // one item in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind worst_fit_block_allocator_unit wfba_checker u_wfba_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
